// ===== rtl/fixed_block_pool_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block pool allocator
// Clocked on clk and disabled while rst_n is low; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
// pre holds -> post holds in the same cycle
`define FBPA_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);
// pre holds -> post holds in the next cycle
`define FBPA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);
`else
`define FBPA_ASSERT_NOW(lbl, pre, post, msg)
`define FBPA_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

// ===== rtl/fbpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fbpa_pkg
// Types and fixed codes shared by the pool allocator controller and datapath.
// ----------------------------------------------------------------------------
package fbpa_pkg;

  localparam int ADDR_W    = 32;
  localparam int SIZE_W    = 13;
  localparam int CHUNK_W   = 9;
  localparam int USED_W    = 21;
  localparam int STAT_W    = 2;
  localparam int CFG_IDX_W = 2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_POOL_BASE       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEM_SIZE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ELEMS_PER_CHUNK = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS      = 2'd3;

  localparam logic [ADDR_W-1:0]  RST_POOL_BASE       = 32'd0;
  localparam logic [SIZE_W-1:0]  RST_ELEM_SIZE       = 13'd16;
  localparam logic [SIZE_W-1:0]  RST_ELEMS_PER_CHUNK = 13'd16;
  localparam logic [CHUNK_W-1:0] RST_MAX_CHUNKS      = 9'd16;

  localparam logic REQ_GET     = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_OOM   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  localparam logic [USED_W-1:0] USED_MAX = {USED_W{1'b1}};

  // datapath operations
  localparam logic [2:0] OP_NONE    = 3'd0;
  localparam logic [2:0] OP_MUL_NE  = 3'd1; // prod = slots per chunk * block size
  localparam logic [2:0] OP_ADD_HDR = 3'd2; // prod += header, chunk stride
  localparam logic [2:0] OP_MUL_CT  = 3'd3; // prod = chunk count * stride
  localparam logic [2:0] OP_OPEN    = 3'd4; // open the next chunk
  localparam logic [2:0] OP_MUL_SL  = 3'd5; // prod = slot index * block size
  localparam logic [2:0] OP_PUSH    = 3'd6; // push released address
  localparam logic [2:0] OP_POP     = 3'd7; // read top of free stack

  // result address source
  localparam logic [1:0] ASEL_ZERO = 2'd0;
  localparam logic [1:0] ASEL_POP  = 2'd1;
  localparam logic [1:0] ASEL_SLOT = 2'd2;

  typedef struct packed {
    logic              req_type;
    logic [ADDR_W-1:0] freed_addr;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] given_addr;
    logic [STAT_W-1:0] status;
    logic [USED_W-1:0] used_count;
  } out_item_t;

  typedef struct packed {
    logic              load_req;
    logic [2:0]        op;
    logic              emit;
    logic [STAT_W-1:0] emit_status;
    logic [1:0]        addr_sel;
  } cmd_t;

  typedef struct packed {
    logic req_release;
    logic free_empty;
    logic free_full;
    logic used_zero;
    logic need_chunk;
    logic at_limit;
    logic out_free;
  } sts_t;

endpackage

// ===== rtl/fixed_block_pool_allocator.sv =====
// Sequence: a release or out-of-memory result is emitted from the decide state; a get
//   from the free stack pops, then emits; a get from an open chunk multiplies, then emits.
// Requests: one at a time, with no new request taken until the controller is back in
//   idle; the sequence runs around one shared 13x32 multiplier and the stack RAM read.
// Reset: synchronous, active low; clears counters, loads default config, no RAM clearing pass.
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Fixed-size block allocator: LIFO free stack in RAM, bump allocation from
// chunks laid out back to back in a pool region, with chunk limit.
// ----------------------------------------------------------------------------
module fixed_block_pool_allocator #(
  parameter int FREE_DEPTH     = 1024,
  parameter int HEADER_BYTES   = 16,
  parameter int MIN_ELEM_BYTES = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]    cfg_data,
  // request channel
  input  logic                           in_valid,
  output logic                           in_ready,
  input  fbpa_pkg::in_item_t             in_item,
  // result channel
  output logic                           out_valid,
  input  logic                           out_ready,
  output fbpa_pkg::out_item_t            out_item
);

  fbpa_pkg::cmd_t cmd;
  fbpa_pkg::sts_t sts;

  // Config writes are always taken; the user must issue them only while the block is
  // idle: the block does not enforce this and has no interlock with a request in flight.
  assign cfg_ready = 1'b1;

  // Controller: one request at a time. A request is taken only in idle; the
  // result register lets a new request transfer in while the previous result
  // still waits on the output. Emitting steps stall until the result register
  // is free, with no state change until then.
  fbpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath: the free stack lives in a RAM with registered read, so a popped address
  // is taken from the read register in the pop-out step. A new chunk start is built from
  // slots * size, + header, * chunk count, + base + header, each product held
  // in a register before the next step. Block address = chunk first block +
  // slot index * size, using the block size current at the time of the get.
  fbpa_dpath #(
    .FREE_DEPTH     (FREE_DEPTH),
    .HEADER_BYTES   (HEADER_BYTES),
    .MIN_ELEM_BYTES (MIN_ELEM_BYTES)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== rtl/fbpa_ram.sv =====
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fbpa_ctrl.sv =====
// ----------------------------------------------------------------------------
// fbpa_ctrl
// Request sequencer: decides the path of each request and steps the datapath.
// ----------------------------------------------------------------------------
module fbpa_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  fbpa_pkg::sts_t sts,
  output fbpa_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_DECIDE  = 3'd1;
  localparam logic [2:0] S_POP_OUT = 3'd2;
  localparam logic [2:0] S_HDR     = 3'd3;
  localparam logic [2:0] S_MULCT   = 3'd4;
  localparam logic [2:0] S_OPEN    = 3'd5;
  localparam logic [2:0] S_MULSL   = 3'd6;
  localparam logic [2:0] S_GIVE    = 3'd7;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_req = 1'b1;
          state_nxt    = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.req_release) begin
          if (sts.out_free) begin
            cmd.emit     = 1'b1;
            cmd.addr_sel = fbpa_pkg::ASEL_ZERO;
            if (sts.used_zero) begin
              cmd.emit_status = fbpa_pkg::ST_EMPTY;
            end else if (sts.free_full) begin
              cmd.emit_status = fbpa_pkg::ST_FULL;
            end else begin
              cmd.emit_status = fbpa_pkg::ST_OK;
              cmd.op          = fbpa_pkg::OP_PUSH;
            end
            state_nxt = S_IDLE;
          end
        end else if (!sts.free_empty) begin
          cmd.op    = fbpa_pkg::OP_POP;
          state_nxt = S_POP_OUT;
        end else if (sts.need_chunk) begin
          if (sts.at_limit) begin
            if (sts.out_free) begin
              cmd.emit        = 1'b1;
              cmd.addr_sel    = fbpa_pkg::ASEL_ZERO;
              cmd.emit_status = fbpa_pkg::ST_OOM;
              state_nxt       = S_IDLE;
            end
          end else begin
            cmd.op    = fbpa_pkg::OP_MUL_NE;
            state_nxt = S_HDR;
          end
        end else begin
          cmd.op    = fbpa_pkg::OP_MUL_SL;
          state_nxt = S_GIVE;
        end
      end
      S_POP_OUT: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.addr_sel    = fbpa_pkg::ASEL_POP;
          cmd.emit_status = fbpa_pkg::ST_OK;
          state_nxt       = S_IDLE;
        end
      end
      S_HDR: begin
        cmd.op    = fbpa_pkg::OP_ADD_HDR;
        state_nxt = S_MULCT;
      end
      S_MULCT: begin
        cmd.op    = fbpa_pkg::OP_MUL_CT;
        state_nxt = S_OPEN;
      end
      S_OPEN: begin
        cmd.op    = fbpa_pkg::OP_OPEN;
        state_nxt = S_MULSL;
      end
      S_MULSL: begin
        cmd.op    = fbpa_pkg::OP_MUL_SL;
        state_nxt = S_GIVE;
      end
      S_GIVE: begin
        if (sts.out_free) begin
          cmd.emit        = 1'b1;
          cmd.addr_sel    = fbpa_pkg::ASEL_SLOT;
          cmd.emit_status = fbpa_pkg::ST_OK;
          state_nxt       = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== rtl/fbpa_dpath.sv =====
// ----------------------------------------------------------------------------
// fbpa_dpath
// Allocator state, configuration, shared multiplier, free stack and result.
// ----------------------------------------------------------------------------
`include "fixed_block_pool_allocator_assert.svh"

module fbpa_dpath #(
  parameter int FREE_DEPTH     = 1024,
  parameter int HEADER_BYTES   = 16,
  parameter int MIN_ELEM_BYTES = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_wr,
  input  logic [fbpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fbpa_pkg::ADDR_W-1:0]        cfg_data,
  input  fbpa_pkg::in_item_t                 in_item,
  input  logic                               out_ready,
  output logic                               out_valid,
  output fbpa_pkg::out_item_t                out_item,
  input  fbpa_pkg::cmd_t                     cmd,
  output fbpa_pkg::sts_t                     sts
);

  localparam int IDX_W = $clog2(FREE_DEPTH);
  localparam int FC_W  = IDX_W + 1;
  localparam int AW    = fbpa_pkg::ADDR_W;
  localparam int SW    = fbpa_pkg::SIZE_W;
  localparam int CW    = fbpa_pkg::CHUNK_W;
  localparam int UW    = fbpa_pkg::USED_W;

  // configuration
  logic [AW-1:0] pool_base_r;
  logic [SW-1:0] elem_size_r;
  logic [SW-1:0] elems_per_chunk_r;
  logic [CW-1:0] max_chunks_r;

  // allocator state
  logic [FC_W-1:0] free_count_r, free_count_nxt;
  logic [UW-1:0]   used_r, used_nxt;
  logic [SW-1:0]   slot_index_r, slot_index_nxt;
  logic [AW-1:0]   next_slot_r, next_slot_nxt;
  logic [CW-1:0]   chunk_total_r, chunk_total_nxt;
  logic [AW-1:0]   prod_r, prod_nxt;

  logic            req_type_r;
  logic [AW-1:0]   req_addr_r;

  logic                out_valid_r, out_valid_nxt;
  fbpa_pkg::out_item_t out_item_r, out_item_nxt;

  logic [SW-1:0]    esz;
  logic [SW-1:0]    n_eff;
  logic [SW-1:0]    mul_x;
  logic [AW-1:0]    mul_y;
  logic [AW+SW-1:0] mul_p;
  logic [FC_W-1:0]  fc_dec;
  logic [AW-1:0]    given;

  logic             mem_we, mem_re;
  logic [AW-1:0]    mem_rdata;

  assign esz   = (elem_size_r < SW'(MIN_ELEM_BYTES)) ? SW'(MIN_ELEM_BYTES) : elem_size_r;
  assign n_eff = (elems_per_chunk_r == '0) ? SW'(1) : elems_per_chunk_r;

  // one shared multiplier, product always registered in prod_r
  always_comb begin
    case (cmd.op)
      fbpa_pkg::OP_MUL_CT: begin
        mul_x = SW'(chunk_total_r);
        mul_y = prod_r;
      end
      fbpa_pkg::OP_MUL_NE: begin
        mul_x = n_eff;
        mul_y = AW'(esz);
      end
      default: begin
        mul_x = slot_index_r;
        mul_y = AW'(esz);
      end
    endcase
  end

  assign mul_p  = mul_x * mul_y;
  assign fc_dec = free_count_r - FC_W'(1);

  always_comb begin
    free_count_nxt  = free_count_r;
    used_nxt        = used_r;
    slot_index_nxt  = slot_index_r;
    next_slot_nxt   = next_slot_r;
    chunk_total_nxt = chunk_total_r;
    prod_nxt        = prod_r;
    mem_we          = 1'b0;
    mem_re          = 1'b0;
    given           = '0;

    case (cmd.op)
      fbpa_pkg::OP_MUL_NE,
      fbpa_pkg::OP_MUL_CT,
      fbpa_pkg::OP_MUL_SL: begin
        prod_nxt = mul_p[AW-1:0];
      end
      fbpa_pkg::OP_ADD_HDR: begin
        prod_nxt = prod_r + AW'(HEADER_BYTES);
      end
      fbpa_pkg::OP_OPEN: begin
        next_slot_nxt   = pool_base_r + prod_r + AW'(HEADER_BYTES);
        slot_index_nxt  = '0;
        chunk_total_nxt = chunk_total_r + CW'(1);
      end
      fbpa_pkg::OP_PUSH: begin
        mem_we         = 1'b1;
        free_count_nxt = free_count_r + FC_W'(1);
        used_nxt       = used_r - UW'(1);
      end
      fbpa_pkg::OP_POP: begin
        mem_re         = 1'b1;
        free_count_nxt = fc_dec;
      end
      default: begin
      end
    endcase

    if (cmd.emit) begin
      case (cmd.addr_sel)
        fbpa_pkg::ASEL_POP: begin
          given = mem_rdata;
        end
        fbpa_pkg::ASEL_SLOT: begin
          given          = next_slot_r + prod_r;
          slot_index_nxt = slot_index_r + SW'(1);
        end
        default: begin
          given = '0;
        end
      endcase
      if ((cmd.addr_sel != fbpa_pkg::ASEL_ZERO) && (used_r != fbpa_pkg::USED_MAX)) begin
        used_nxt = used_r + UW'(1);
      end
    end

    if (cmd.emit) begin
      out_valid_nxt           = 1'b1;
      out_item_nxt.given_addr = given;
      out_item_nxt.status     = cmd.emit_status;
      out_item_nxt.used_count = used_nxt;
    end else begin
      out_valid_nxt = out_ready ? 1'b0 : out_valid_r;
      out_item_nxt  = out_item_r;
    end
  end

  fbpa_ram #(
    .WIDTH (AW),
    .DEPTH (FREE_DEPTH)
  ) u_free_stack (
    .clk   (clk),
    .we    (mem_we),
    .waddr (free_count_r[IDX_W-1:0]),
    .wdata (req_addr_r),
    .re    (mem_re),
    .raddr (fc_dec[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_base_r       <= fbpa_pkg::RST_POOL_BASE;
      elem_size_r       <= fbpa_pkg::RST_ELEM_SIZE;
      elems_per_chunk_r <= fbpa_pkg::RST_ELEMS_PER_CHUNK;
      max_chunks_r      <= fbpa_pkg::RST_MAX_CHUNKS;
      free_count_r      <= '0;
      used_r            <= '0;
      slot_index_r      <= fbpa_pkg::RST_ELEMS_PER_CHUNK;
      next_slot_r       <= '0;
      chunk_total_r     <= '0;
      out_valid_r       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_index)
          fbpa_pkg::CFG_POOL_BASE:       pool_base_r       <= cfg_data;
          fbpa_pkg::CFG_ELEM_SIZE:       elem_size_r       <= cfg_data[SW-1:0];
          fbpa_pkg::CFG_ELEMS_PER_CHUNK: elems_per_chunk_r <= cfg_data[SW-1:0];
          fbpa_pkg::CFG_MAX_CHUNKS:      max_chunks_r      <= cfg_data[CW-1:0];
          default: begin
          end
        endcase
      end
      free_count_r  <= free_count_nxt;
      used_r        <= used_nxt;
      slot_index_r  <= slot_index_nxt;
      next_slot_r   <= next_slot_nxt;
      chunk_total_r <= chunk_total_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    prod_r     <= prod_nxt;
    out_item_r <= out_item_nxt;
    if (cmd.load_req) begin
      req_type_r <= in_item.req_type;
      req_addr_r <= in_item.freed_addr;
    end
  end

  assign sts.req_release = (req_type_r == fbpa_pkg::REQ_RELEASE);
  assign sts.free_empty  = (free_count_r == '0);
  assign sts.free_full   = (free_count_r >= FC_W'(FREE_DEPTH));
  assign sts.used_zero   = (used_r == '0);
  assign sts.need_chunk  = (slot_index_r >= n_eff);
  assign sts.at_limit    = (chunk_total_r >= max_chunks_r);
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  `FBPA_ASSERT_NOW(a_push_guard, cmd.op == fbpa_pkg::OP_PUSH, !sts.free_full && !sts.used_zero, "push into full stack or with nothing in use")
  `FBPA_ASSERT_NOW(a_pop_guard, cmd.op == fbpa_pkg::OP_POP, !sts.free_empty, "pop from empty free stack")
  `FBPA_ASSERT_NOW(a_emit_room, cmd.emit, sts.out_free, "result loaded over an untaken result")
  `FBPA_ASSERT_NOW(a_valid_src, $rose(out_valid_r), $past(cmd.emit), "result valid without an emit")
  `FBPA_ASSERT_NEXT(a_push_fill, cmd.op == fbpa_pkg::OP_PUSH, !sts.free_empty, "free stack empty after a push")

endmodule
